// File: sv/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad combination lock
// Key codes, event codes, mode encoding, code buffer types and the result
// bundle passed from the lock core to the output stage.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Code buffer geometry
  localparam int MAX_DIGITS = 6;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DIGIT_W    = 4;

  // Factory code 1 2 3 4, cut to the buffer size
  localparam int RESET_LEN  = (MAX_DIGITS < 4) ? MAX_DIGITS : 4;

  // Fixed field widths on the ports
  localparam int KEY_W      = 4;
  localparam int EV_W       = 4;
  localparam int MODE_W     = 3;
  localparam int LEN_W      = 3;
  localparam int TRIES_W    = 4;

  // Configuration port
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam logic [ADDR_W-3:0] REG_ATTEMPT_LIMIT = '0;
  localparam logic [TRIES_W-1:0] LIMIT_RESET = TRIES_W'(3);

  // Input kinds
  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_REMOTE = 1'b1;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd14;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd15;

  typedef enum logic [EV_W-1:0] {
    EV_TAKEN    = 4'd0,
    EV_FULL     = 4'd1,
    EV_EMPTY    = 4'd2,
    EV_GRANTED  = 4'd3,
    EV_WRONG    = 4'd4,
    EV_LOCKOUT  = 4'd5,
    EV_BADCUR   = 4'd6,
    EV_CANCEL   = 4'd7,
    EV_SAVED    = 4'd8,
    EV_MISMATCH = 4'd9,
    EV_IGNORED  = 4'd10,
    EV_REMOTE   = 4'd11,
    EV_HINT     = 4'd12,
    EV_CUROK    = 4'd13,
    EV_NEWTAKEN = 4'd14
  } ev_code_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL  = 3'd0,
    MODE_CUR     = 3'd1,
    MODE_NEW     = 3'd2,
    MODE_CONFIRM = 3'd3,
    MODE_LOCKED  = 3'd4
  } mode_t;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;
  typedef logic [CNT_W-1:0] count_t;

  // Outcome of one item, as seen after the item
  typedef struct packed {
    ev_code_t            ev;
    mode_t               mode;
    count_t              len;
    logic [TRIES_W-1:0]  tries;
  } result_t;

endpackage

// File: sv/kcl_code_cmp.sv
// ----------------------------------------------------------------------------
// kcl_code_cmp: code comparator
// Two codes match when their lengths are equal and every held digit agrees.
// ----------------------------------------------------------------------------
module kcl_code_cmp (
  input  kcl_pkg::digits_t a,
  input  kcl_pkg::count_t  na,
  input  kcl_pkg::digits_t b,
  input  kcl_pkg::count_t  nb,
  output logic             equal
);
  import kcl_pkg::*;

  logic [MAX_DIGITS-1:0] digit_ok;

  // Per-position check, positions past the length always pass
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit_ok[i] = (count_t'(i) >= na) || (a[i] == b[i]);
    end
  end

  assign equal = (na == nb) && (&digit_ok);

endmodule

// File: sv/kcl_cfg.sv
// ----------------------------------------------------------------------------
// kcl_cfg: configuration register port
// APB-style slave holding the attempt limit register.
// ----------------------------------------------------------------------------
module kcl_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0]        paddr,
  input  logic [kcl_pkg::DATA_W-1:0]        pwdata,
  output logic [kcl_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  output logic [kcl_pkg::TRIES_W-1:0]       attempt_limit
);
  import kcl_pkg::*;

  logic                 wr_en;
  logic                 sel_limit;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[ADDR_W-1:2] == REG_ATTEMPT_LIMIT);
  assign wr_en     = psel && penable && pwrite && pready && sel_limit;

  // Attempt limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      attempt_limit <= pwdata[TRIES_W-1:0];
    end
  end

  // Read back
  assign prdata = sel_limit ? DATA_W'(attempt_limit) : '0;

endmodule

// File: sv/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: lock state and next-state decision
// Holds the entry buffer, stored code, pending new code, attempt count and
// mode, and works out one key or remote event per cycle in which step is high.
// ----------------------------------------------------------------------------
module kcl_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         kind,
  input  logic [kcl_pkg::KEY_W-1:0]    key,
  input  logic [kcl_pkg::TRIES_W-1:0]  attempt_limit,
  output kcl_pkg::result_t             result
);
  import kcl_pkg::*;

  mode_t               mode, mode_next;
  digits_t             entry_digits, entry_digits_next;
  count_t              entry_count, entry_count_next;
  digits_t             stored_digits, stored_digits_next;
  count_t              stored_count, stored_count_next;
  digits_t             pending_digits, pending_digits_next;
  count_t              pending_count, pending_count_next;
  logic [TRIES_W-1:0]  tries_left, tries_left_next;
  ev_code_t            ev;

  logic                match_stored;
  logic                match_pending;
  logic [IDX_W-1:0]    push_idx;
  logic [IDX_W-1:0]    pop_idx;

  // Entry against stored code and against pending new code
  kcl_code_cmp u_cmp_stored (
    .a     (entry_digits),
    .na    (entry_count),
    .b     (stored_digits),
    .nb    (stored_count),
    .equal (match_stored)
  );

  kcl_code_cmp u_cmp_pending (
    .a     (entry_digits),
    .na    (entry_count),
    .b     (pending_digits),
    .nb    (pending_count),
    .equal (match_pending)
  );

  assign push_idx = entry_count[IDX_W-1:0];
  assign pop_idx  = IDX_W'(entry_count - 1'b1);

  // Next-state decision for one item
  always_comb begin
    mode_next           = mode;
    entry_digits_next   = entry_digits;
    entry_count_next    = entry_count;
    stored_digits_next  = stored_digits;
    stored_count_next   = stored_count;
    pending_digits_next = pending_digits;
    pending_count_next  = pending_count;
    tries_left_next     = tries_left;
    ev                  = EV_TAKEN;

    if (mode == MODE_LOCKED) begin
      // Only a remote command gets through
      if (kind == KIND_REMOTE) begin
        mode_next         = MODE_NORMAL;
        tries_left_next   = attempt_limit;
        entry_digits_next = '0;
        entry_count_next  = '0;
        ev                = EV_REMOTE;
      end else begin
        ev = EV_IGNORED;
      end
    end else if (kind == KIND_REMOTE) begin
      ev = EV_IGNORED;
    end else if (key == KEY_STAR) begin
      // Star opens the change flow, or cancels it
      entry_digits_next = '0;
      entry_count_next  = '0;
      if (mode == MODE_NORMAL) begin
        mode_next = MODE_CUR;
        ev        = EV_TAKEN;
      end else begin
        mode_next = MODE_NORMAL;
        ev        = EV_CANCEL;
      end
    end else if (key == KEY_HASH) begin
      // Submit
      unique case (mode)
        MODE_CUR: begin
          entry_digits_next = '0;
          entry_count_next  = '0;
          mode_next         = match_stored ? MODE_NEW : MODE_NORMAL;
          ev                = match_stored ? EV_CUROK : EV_BADCUR;
        end
        MODE_NEW: begin
          if (entry_count == '0) begin
            ev = EV_EMPTY;
          end else begin
            pending_digits_next = entry_digits;
            pending_count_next  = entry_count;
            entry_digits_next   = '0;
            entry_count_next    = '0;
            mode_next           = MODE_CONFIRM;
            ev                  = EV_NEWTAKEN;
          end
        end
        MODE_CONFIRM: begin
          if (entry_count == '0) begin
            ev = EV_EMPTY;
          end else begin
            if (match_pending) begin
              stored_digits_next = pending_digits;
              stored_count_next  = pending_count;
            end
            entry_digits_next = '0;
            entry_count_next  = '0;
            mode_next         = MODE_NORMAL;
            ev                = match_pending ? EV_SAVED : EV_MISMATCH;
          end
        end
        default: begin
          // Normal entry: grant, wrong code or lockout
          if (entry_count == '0) begin
            ev = EV_EMPTY;
          end else begin
            entry_digits_next = '0;
            entry_count_next  = '0;
            if (match_stored) begin
              tries_left_next = attempt_limit;
              ev              = EV_GRANTED;
            end else if (tries_left <= TRIES_W'(1)) begin
              tries_left_next = '0;
              mode_next       = MODE_LOCKED;
              ev              = EV_LOCKOUT;
            end else begin
              tries_left_next = tries_left - 1'b1;
              ev              = EV_WRONG;
            end
          end
        end
      endcase
    end else if (key == KEY_C) begin
      // Backspace, no effect on an empty buffer
      if (entry_count != '0) begin
        entry_count_next           = entry_count - 1'b1;
        entry_digits_next[pop_idx] = '0;
      end
    end else if (key < KEY_A) begin
      // Digit append, dropped when the buffer is full
      if (entry_count < count_t'(MAX_DIGITS)) begin
        entry_digits_next[push_idx] = key;
        entry_count_next            = entry_count + 1'b1;
      end else begin
        ev = EV_FULL;
      end
    end else begin
      // Letters A, B, D
      ev = (mode == MODE_NORMAL) ? EV_HINT : EV_TAKEN;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      entry_digits   <= '0;
      entry_count    <= '0;
      pending_digits <= '0;
      pending_count  <= '0;
      tries_left     <= LIMIT_RESET;
      stored_count   <= count_t'(RESET_LEN);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_digits[i] <= (i < RESET_LEN) ? DIGIT_W'(i + 1) : '0;
      end
    end else if (step) begin
      mode           <= mode_next;
      entry_digits   <= entry_digits_next;
      entry_count    <= entry_count_next;
      stored_digits  <= stored_digits_next;
      stored_count   <= stored_count_next;
      pending_digits <= pending_digits_next;
      pending_count  <= pending_count_next;
      tries_left     <= tries_left_next;
    end
  end

  assign result = '{ev: ev, mode: mode_next, len: entry_count_next, tries: tries_left_next};

`ifndef SYNTHESIS
  // Entry and pending buffer lengths never pass the buffer size
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    (entry_count <= count_t'(MAX_DIGITS)) && (pending_count <= count_t'(MAX_DIGITS))
  ) else $error("code buffer length out of range");

  // Locked mode always comes with no attempts left
  a_locked_tries: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_LOCKED) |-> (tries_left == '0)
  ) else $error("locked with attempts left");

  // A keypad press while locked changes nothing
  a_locked_hold: assert property (@(posedge clk) disable iff (rst)
    (step && (mode == MODE_LOCKED) && (kind == KIND_KEY)) |=>
      ((mode == MODE_LOCKED) && $stable(entry_count) && $stable(stored_digits))
  ) else $error("state changed on a key while locked");

  // The stored code only changes on a confirmed save
  a_store_on_save: assert property (@(posedge clk) disable iff (rst)
    (step && (ev != EV_SAVED)) |=> $stable(stored_digits) && $stable(stored_count)
  ) else $error("stored code changed without a save");
`endif

endmodule

// File: sv/keypad_combination_lock.sv
// ----------------------------------------------------------------------------
// keypad_combination_lock: keypad combination lock with change-code flow
// Top level: input handshake, lock core, configuration port, result register.
// ----------------------------------------------------------------------------
// The lock takes one key or remote-unlock transfer per clock and returns one
// result transfer for each in the cycle after it is accepted. The whole
// decision for an item (six-digit code compare, attempt count, mode change)
// is combinational, between the state registers and the result register, so
// a new item is taken every cycle while the result register is empty or being
// drained; only a stalled result register holds off input. Register 0 at
// byte address 0 is the attempt limit (reset 3), loaded into the attempt
// count on a grant or a remote unlock. The stored code resets to 1 2 3 4.
module keypad_combination_lock (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [3:0] key_code
  input  logic                              s_tuser,  // [0] kind
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] event_res, [6:4] mode_now, [9:7] entry_length,
  // [13:10] attempts_remaining
  output logic [15:0]                       m_tdata,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0]        paddr,
  input  logic [kcl_pkg::DATA_W-1:0]        pwdata,
  output logic [kcl_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import kcl_pkg::*;

  logic                 step;
  logic [TRIES_W-1:0]   attempt_limit;
  result_t              result;
  logic [15:0]          out_data;

  // Input accepted whenever the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  kcl_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .attempt_limit (attempt_limit)
  );

  kcl_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .kind          (s_tuser),
    .key           (s_tdata[KEY_W-1:0]),
    .attempt_limit (attempt_limit),
    .result        (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= {2'b00, result.tries, LEN_W'(result.len), result.mode, result.ev};
    end
  end

  assign m_tdata = out_data;

endmodule
